[sv/clas_pkg.sv]
`timescale 1ns / 1ps

package clas_pkg;

   // Width of the backslash and quote run counters.
   localparam int RUN_BITS = 16;
   // Number of argument indexes; the index saturates at the last one (or 255).
   localparam int MAX_ARGS = 256;
   localparam int IDX_MAX  = ((MAX_ARGS - 1) < 255) ? (MAX_ARGS - 1) : 255;
   // Width that holds any count before it is clamped to the 16-bit field.
   localparam int CNT_W    = (RUN_BITS > 16) ? RUN_BITS : 16;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SPC = 8'h20;
   localparam logic [7:0] CH_QUO = 8'h22;
   localparam logic [7:0] CH_BSL = 8'h5C;

   typedef logic [RUN_BITS-1:0] run_type;
   localparam run_type RUN_MAX = '1;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_ARG,
      PH_GAP
   } phase_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic [15:0] repeat_count;
      logic        arg_end;
      logic        line_end;
      logic [7:0]  arg_number;
      logic        run_overflow;
   } item_type;

   // Up to two result items produced by one input item, in output order.
   typedef struct packed {
      logic [1:0] count;
      item_type   first_item;
      item_type   second_item;
   } push_type;

   function automatic item_type make_item(input logic [7:0] c, input logic [CNT_W-1:0] cnt,
                                          input logic ae, input logic le,
                                          input logic [7:0] idx, input logic ovf);
      item_type it;
      it.out_char   = c;
      it.arg_end    = ae;
      it.line_end   = le;
      it.arg_number = idx;
      if (cnt > CNT_W'(16'hFFFF)) begin
         it.repeat_count = 16'hFFFF;
         it.run_overflow = 1'b1;
      end else begin
         it.repeat_count = cnt[15:0];
         it.run_overflow = ovf;
      end
      return it;
   endfunction

   function automatic push_type put_item(input push_type p, input item_type it);
      push_type q;
      q = p;
      if (p.count == 2'd0) begin
         q.first_item = it;
      end else begin
         q.second_item = it;
      end
      q.count = p.count + 2'd1;
      return q;
   endfunction

endpackage

[sv/clas_parser.sv]
`timescale 1ns / 1ps

module clas_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [7:0]         ch,
   output clas_pkg::push_type push
);
   import clas_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       first_ff, first_in;
   logic       quote_ff, quote_in;
   run_type    bs_ff, bs_in;
   run_type    qr_ff, qr_in;
   run_type    qdiv_ff, qdiv_in;
   logic [1:0] qmod_ff, qmod_in;
   logic [7:0] idx_ff, idx_in;
   logic       sat_ff, sat_in;

   push_type   res;
   logic       body;
   logic       skip;
   logic       clear;
   logic       delim;
   logic       ovf;

   assign delim = (ch == CH_SPC) || (ch == CH_TAB);

   always_comb begin
      phase_in = phase_ff;
      first_in = first_ff;
      quote_in = quote_ff;
      bs_in    = bs_ff;
      qr_in    = qr_ff;
      qdiv_in  = qdiv_ff;
      qmod_in  = qmod_ff;
      idx_in   = idx_ff;
      sat_in   = sat_ff;
      res      = '0;
      body     = 1'b0;
      skip     = 1'b0;
      clear    = 1'b0;
      ovf      = sat_ff;

      if (phase_ff != PH_ARG) begin
         if (ch == CH_NUL) begin
            res   = put_item(res, make_item(CH_NUL, '0, phase_ff == PH_LEAD, 1'b1,
                                            idx_ff, 1'b0));
            clear = 1'b1;
         end else if (!delim) begin
            if (phase_ff == PH_LEAD) begin
               first_in = 1'b1;
               idx_in   = 8'd0;
            end else begin
               first_in = 1'b0;
               if (idx_ff < 8'(IDX_MAX)) begin
                  idx_in = idx_ff + 8'd1;
               end
            end
            phase_in = PH_ARG;
            quote_in = 1'b0;
            bs_in    = '0;
            qr_in    = '0;
            qdiv_in  = '0;
            qmod_in  = 2'd1;
            sat_in   = 1'b0;
            body     = 1'b1;
         end
      end else begin
         body = 1'b1;
      end

      if (body && first_in) begin
         // The first argument only toggles quoting; backslashes are literal.
         if (ch == CH_NUL) begin
            res   = put_item(res, make_item(CH_NUL, '0, 1'b1, 1'b1, idx_in, 1'b0));
            clear = 1'b1;
         end else if (!quote_in && delim) begin
            res      = put_item(res, make_item(CH_NUL, '0, 1'b1, 1'b0, idx_in, 1'b0));
            phase_in = PH_GAP;
         end else if (ch == CH_QUO) begin
            quote_in = !quote_in;
         end else begin
            res = put_item(res, make_item(ch, CNT_W'(1), 1'b0, 1'b0, idx_in, 1'b0));
         end
      end else if (body) begin
         ovf = sat_in;
         if (bs_in != '0) begin
            if (ch == CH_BSL) begin
               if (bs_in != RUN_MAX) begin
                  bs_in = bs_in + run_type'(1);
               end else begin
                  sat_in = 1'b1;
               end
               skip = 1'b1;
            end else begin
               sat_in = 1'b0;
               if (ch == CH_QUO) begin
                  if ((bs_in >> 1) != '0) begin
                     res = put_item(res, make_item(CH_BSL, CNT_W'(bs_in >> 1), 1'b0, 1'b0,
                                                   idx_in, ovf));
                  end
                  if (bs_in[0]) begin
                     // An odd run escapes the quote, which is consumed here.
                     res  = put_item(res, make_item(CH_QUO, CNT_W'(1), 1'b0, 1'b0,
                                                    idx_in, ovf));
                     skip = 1'b1;
                  end
               end else begin
                  res = put_item(res, make_item(CH_BSL, CNT_W'(bs_in), 1'b0, 1'b0,
                                                idx_in, ovf));
               end
               bs_in = '0;
            end
         end else if (qr_in != '0) begin
            if (ch == CH_QUO) begin
               if (qr_in != RUN_MAX) begin
                  qr_in = qr_in + run_type'(1);
                  if (qmod_in == 2'd2) begin
                     qmod_in = 2'd0;
                     qdiv_in = qdiv_in + run_type'(1);
                  end else begin
                     qmod_in = qmod_in + 2'd1;
                  end
               end else begin
                  sat_in = 1'b1;
               end
               skip = 1'b1;
            end else begin
               sat_in = 1'b0;
               if (qdiv_in != '0) begin
                  res = put_item(res, make_item(CH_QUO, CNT_W'(qdiv_in), 1'b0, 1'b0,
                                                idx_in, ovf));
               end
               quote_in = (qmod_in == 2'd1);
               qr_in    = '0;
               qdiv_in  = '0;
               qmod_in  = 2'd1;
            end
         end

         if (!skip) begin
            if (ch == CH_NUL) begin
               res   = put_item(res, make_item(CH_NUL, '0, 1'b1, 1'b1, idx_in, 1'b0));
               clear = 1'b1;
            end else if (!quote_in && delim) begin
               res      = put_item(res, make_item(CH_NUL, '0, 1'b1, 1'b0, idx_in, 1'b0));
               phase_in = PH_GAP;
            end else if (ch == CH_BSL) begin
               bs_in = bs_in + run_type'(1);
            end else if (ch == CH_QUO) begin
               if (quote_in) begin
                  // Run of one quote: (run + 1) is 2, so div 0 and mod 2.
                  qr_in   = qr_in + run_type'(1);
                  qmod_in = 2'd2;
               end else begin
                  quote_in = 1'b1;
               end
            end else begin
               res = put_item(res, make_item(ch, CNT_W'(1), 1'b0, 1'b0, idx_in, 1'b0));
            end
         end
      end

      if (clear) begin
         phase_in = PH_LEAD;
         first_in = 1'b1;
         quote_in = 1'b0;
         bs_in    = '0;
         qr_in    = '0;
         qdiv_in  = '0;
         qmod_in  = 2'd1;
         idx_in   = 8'd0;
         sat_in   = 1'b0;
      end
   end

   always_comb begin
      push = res;
      if (!go) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         first_ff <= 1'b1;
         quote_ff <= 1'b0;
         bs_ff    <= '0;
         qr_ff    <= '0;
         qdiv_ff  <= '0;
         qmod_ff  <= 2'd1;
         idx_ff   <= 8'd0;
         sat_ff   <= 1'b0;
      end else if (go) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         quote_ff <= quote_in;
         bs_ff    <= bs_in;
         qr_ff    <= qr_in;
         qdiv_ff  <= qdiv_in;
         qmod_ff  <= qmod_in;
         idx_ff   <= idx_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

[sv/clas_queue.sv]
`timescale 1ns / 1ps

module clas_queue (
   input  logic               clock,
   input  logic               reset,
   input  clas_pkg::push_type push,
   input  logic               pop,
   output logic               head_valid,
   output clas_pkg::item_type head,
   output logic               space_ok
);
   import clas_pkg::*;

   item_type   mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop_fire;

   assign head_valid = (count_ff != 3'd0);
   assign head       = mem_ff[rd_ptr_ff];
   // Room for the two items one input item can produce.
   assign space_ok   = (count_ff <= 3'd2);
   assign pop_fire   = head_valid && pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop_fire};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop_fire};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first_item;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.second_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/command_line_argument_splitter.sv]
`timescale 1ns / 1ps

// Channel    Direction  Carries
// req_*      in         one command-line byte per item; a 0 byte ends the line
// rsp_*      out        one run of argument bytes or one end marker per item
//
// An input item is held in the input register, is parsed there, and its
// results enter a four-entry output queue, from whose head they appear on
// rsp_. One input item is taken per cycle while the queue has room for
// two results, so the sustained rate is then one item per cycle, set by
// the combinational parse between input register and queue.
// Reset returns the parser to the start of a line and empties the queue.
// A stall on rsp_tready fills the queue, after which req_tready drops until
// the queue has room again; no result is lost or repeated.
module command_line_argument_splitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_char, [23:8] repeat_count, [31:24] arg_number
   output logic        rsp_tlast,   // arg_end
   output logic [1:0]  rsp_tuser    // [0] line_end, [1] run_overflow
);
   import clas_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       go;
   logic       space_ok;
   push_type   push;
   item_type   head;

   // The held byte is parsed in the cycle the queue can take its results.
   assign go          = in_valid_ff && space_ok;
   assign req_tready  = !in_valid_ff || go;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff <= req_tdata;
      end
   end

   clas_parser u_parser (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .ch    (in_ch_ff),
      .push  (push)
   );

   clas_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .space_ok   (space_ok)
   );

   assign rsp_tdata = {head.arg_number, head.repeat_count, head.out_char};
   assign rsp_tlast = head.arg_end;
   assign rsp_tuser = {head.run_overflow, head.line_end};

endmodule

[sv/clas_checker.sv]
`timescale 1ns / 1ps

module clas_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);
   import clas_pkg::*;

   // A waiting result item holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // Markers carry no characters.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tlast || rsp_tuser[0]) |->
         rsp_tdata[23:8] == 16'd0 && rsp_tdata[7:0] == CH_NUL)
      else $error("end marker carries characters");

   // An item with no characters must be a marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[23:8] == 16'd0 |-> rsp_tlast || rsp_tuser[0])
      else $error("empty item that is not a marker");

   // Only backslash and quote runs can overflow.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[7:0] == CH_BSL || rsp_tdata[7:0] == CH_QUO)
      else $error("overflow flag on a plain character");

   // A block that has just left reset holds nothing and takes input at once.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> req_tready)
      else $error("input not ready after reset");

endmodule

bind command_line_argument_splitter clas_checker u_checker (.*);

[bench/command_line_argument_splitter_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the command-line argument splitter.
//
// Bytes go in on the req_ channel. Each accepted byte is run through a local
// model of the splitter. The result items that the model predicts wait in a
// queue until the rsp_ channel delivers them, and every delivered item is
// compared field by field with the oldest prediction. Inputs change on the
// falling clock edge and both channels are sampled on the rising edge.
module command_line_argument_splitter_tb;
   import clas_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 7;
   // Input items to send in all, the directed table included.
   localparam int TOTAL_ITEMS = 480;
   // An input item passes the input register and the output queue before its results
   // can be taken. The drain wait at the end covers that path with a wide margin.
   localparam int DRAIN_CYCLES = 16;
   // Each byte costs at most a sender gap plus the receiver stall for its up to
   // two results. The limit is that cost for every item taken many
   // times over.
   localparam longint CYCLE_LIMIT = 200_000;

   // The patterns on which the receiver stalls.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_PATTERN,
      RX_CHOKED
   } rx_mode_type;

   // One row of the directed table: a byte sent reps times in a row. Where
   // typed is set, the row causes exactly one result, and that result is the
   // want field rather than the model's prediction.
   typedef struct {
      logic [7:0]  ch;
      int unsigned reps;
      logic        typed;
      item_type    want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] ch
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [7:0] out_char, [23:8] repeat_count, [31:24] arg_number
   logic        rsp_tlast;           // arg_end
   logic [1:0]  rsp_tuser;           // [0] line_end, [1] run_overflow

   command_line_argument_splitter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // Splitter model. These variables mirror the parser state inside the
   // block. run_full remembers that the one pending run hit its counter
   // limit.
   // ------------------------------------------------------------------
   phase_type  ph;
   logic       first_arg;
   logic       quoted;
   run_type    bsl_run;
   run_type    quo_run;
   logic [7:0] arg_idx;
   logic       run_full;

   // Results that the last modeled byte produced.
   item_type emitted[$];
   // Results that are predicted but have not yet been seen on rsp_.
   item_type awaited_runs[$];

   row_type    stimulus_rows[$];
   logic [7:0] line_bytes[$];

   int     fail_count      = 0;
   int     bytes_sent      = 0;
   int     lines_sent      = 0;
   int     results_checked = 0;
   int     overflow_seen   = 0;
   int     top_index_seen  = 0;
   longint cycle_count     = 0;

   // The sender works in bursts; burst_left counts down the current burst.
   int burst_left = 0;

   int          mode_left = 0;
   rx_mode_type stall_mode = RX_OPEN;
   logic [10:0] stall_pattern = 11'b101_1001_1101;

   function automatic void clear_state();
      ph        = PH_LEAD;
      first_arg = 1'b1;
      quoted    = 1'b0;
      bsl_run   = '0;
      quo_run   = '0;
      arg_idx   = 8'd0;
      run_full  = 1'b0;
   endfunction

   function automatic logic is_blank(input logic [7:0] ch);
      return ch == CH_SPC || ch == CH_TAB;
   endfunction

   // Appends one result item. A count that does not fit the 16-bit field is
   // clamped and flagged as an overflow.
   function automatic void emit(input logic [7:0] c, input longint unsigned cnt,
                                input logic ae, input logic le, input logic ovf);
      item_type it;
      it.out_char   = c;
      it.arg_end    = ae;
      it.line_end   = le;
      it.arg_number = arg_idx;
      if (cnt > 64'd65535) begin
         it.repeat_count = 16'hFFFF;
         it.run_overflow = 1'b1;
      end else begin
         it.repeat_count = cnt[15:0];
         it.run_overflow = ovf;
      end
      emitted.push_back(it);
   endfunction

   // Counts one more byte of a run. A run counter that is already full keeps
   // its value, and the run is marked as overflowed.
   function automatic run_type bumped(input run_type r);
      if (r != RUN_MAX) begin
         return r + 1'b1;
      end
      run_full = 1'b1;
      return r;
   endfunction

   // Works out the results of one command-line byte and advances the state.
   function automatic void split_byte(input logic [7:0] ch);
      longint unsigned nb;
      longint unsigned r1;
      logic            ovf;
      emitted.delete();

      // Outside an argument: blanks are skipped, and a 0 ends the line. Any
      // other byte opens the next argument.
      if (ph != PH_ARG) begin
         if (ch == CH_NUL) begin
            emit(CH_NUL, 0, ph == PH_LEAD, 1'b1, 1'b0);
            clear_state();
            return;
         end
         if (is_blank(ch)) begin
            return;
         end
         if (ph == PH_LEAD) begin
            first_arg = 1'b1;
            arg_idx   = 8'd0;
         end else begin
            first_arg = 1'b0;
            if (arg_idx < IDX_MAX) begin
               arg_idx = arg_idx + 8'd1;
            end
         end
         ph       = PH_ARG;
         quoted   = 1'b0;
         bsl_run  = '0;
         quo_run  = '0;
         run_full = 1'b0;
      end

      // In the first argument a quote only toggles quoting, and backslashes
      // are literal.
      if (first_arg) begin
         if (ch == CH_NUL) begin
            emit(CH_NUL, 0, 1'b1, 1'b1, 1'b0);
            clear_state();
         end else if (!quoted && is_blank(ch)) begin
            emit(CH_NUL, 0, 1'b1, 1'b0, 1'b0);
            ph = PH_GAP;
         end else if (ch == CH_QUO) begin
            quoted = !quoted;
         end else begin
            emit(ch, 1, 1'b0, 1'b0, 1'b0);
         end
         return;
      end

      // A pending backslash run: a backslash extends it, before a quote it is
      // halved, and an odd run also gives a literal quote that takes the quote
      // byte. Before any other byte the run is literal.
      if (bsl_run != '0) begin
         nb  = bsl_run;
         ovf = run_full;
         if (ch == CH_BSL) begin
            bsl_run = bumped(bsl_run);
            return;
         end
         bsl_run  = '0;
         run_full = 1'b0;
         if (ch == CH_QUO) begin
            if (nb / 2 > 0) begin
               emit(CH_BSL, nb / 2, 1'b0, 1'b0, ovf);
            end
            if (nb[0]) begin
               emit(CH_QUO, 1, 1'b0, 1'b0, ovf);
               return;
            end
         end else begin
            emit(CH_BSL, nb, 1'b0, 1'b0, ovf);
         end
      end else if (quo_run != '0) begin
         // A run of quotes inside quotes: every third one counting the
         // opening quote is literal, and the remainder sets quoting.
         r1  = quo_run + 1;
         ovf = run_full;
         if (ch == CH_QUO) begin
            quo_run = bumped(quo_run);
            return;
         end
         quo_run  = '0;
         run_full = 1'b0;
         if (r1 / 3 > 0) begin
            emit(CH_QUO, r1 / 3, 1'b0, 1'b0, ovf);
         end
         quoted = (r1 % 3) == 1;
      end

      if (ch == CH_NUL) begin
         emit(CH_NUL, 0, 1'b1, 1'b1, 1'b0);
         clear_state();
      end else if (!quoted && is_blank(ch)) begin
         emit(CH_NUL, 0, 1'b1, 1'b0, 1'b0);
         ph = PH_GAP;
      end else if (ch == CH_BSL) begin
         bsl_run = bumped(bsl_run);
      end else if (ch == CH_QUO) begin
         if (quoted) begin
            quo_run = bumped(quo_run);
         end else begin
            quoted = 1'b1;
         end
      end else begin
         emit(ch, 1, 1'b0, 1'b0, 1'b0);
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic void add_row(input logic [7:0] ch, input int unsigned reps);
      row_type r;
      r.ch    = ch;
      r.reps  = reps;
      r.typed = 1'b0;
      r.want  = '0;
      stimulus_rows.push_back(r);
   endfunction

   function automatic void add_typed(input logic [7:0] ch, input item_type want);
      row_type r;
      r.ch    = ch;
      r.reps  = 1;
      r.typed = 1'b1;
      r.want  = want;
      stimulus_rows.push_back(r);
   endfunction

   function automatic logic [7:0] blank_byte();
      return ($urandom_range(0, 1) != 0) ? CH_SPC : CH_TAB;
   endfunction

   function automatic logic [7:0] letter();
      return 8'(8'h61 + $urandom_range(0, 25));
   endfunction

   // Any byte but 0, weighted toward the bytes that the parser treats apart.
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0: return CH_BSL;
         1: return CH_QUO;
         2: return blank_byte();
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // Appends the body of one argument: a few pieces of plain text,
   // backslash runs, quoted stretches and quote runs, in random order.
   function automatic void add_word();
      int pieces;
      int n;
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
         case ($urandom_range(0, 5))
            0: line_bytes.push_back(letter());
            1: line_bytes.push_back(8'($urandom_range(1, 255)));
            2: begin
               n = $urandom_range(1, 6);
               repeat (n) line_bytes.push_back(CH_BSL);
               case ($urandom_range(0, 2))
                  0: line_bytes.push_back(CH_QUO);
                  1: line_bytes.push_back(letter());
                  default: ;
               endcase
            end
            3: begin
               line_bytes.push_back(CH_QUO);
               repeat ($urandom_range(0, 3)) line_bytes.push_back(letter());
               if ($urandom_range(0, 1) != 0) begin
                  line_bytes.push_back(blank_byte());
               end
               n = $urandom_range(1, 7);
               repeat (n) line_bytes.push_back(CH_QUO);
               line_bytes.push_back(letter());
            end
            4: begin
               n = $urandom_range(1, 4);
               repeat (n) line_bytes.push_back(CH_QUO);
            end
            default: begin
               line_bytes.push_back(CH_QUO);
               line_bytes.push_back(blank_byte());
               line_bytes.push_back(CH_QUO);
            end
         endcase
      end
   endfunction

   // A well-formed line: blank-separated arguments, then the 0 byte.
   function automatic void build_line();
      int nargs;
      line_bytes.delete();
      nargs = $urandom_range(1, 6);
      for (int a = 0; a < nargs; a++) begin
         repeat ($urandom_range((a == 0) ? 0 : 1, 3)) line_bytes.push_back(blank_byte());
         add_word();
      end
      repeat ($urandom_range(0, 2)) line_bytes.push_back(blank_byte());
      line_bytes.push_back(CH_NUL);
   endfunction

   // A line of loose bytes, so that runs are broken off at random points.
   function automatic void build_noise_line();
      line_bytes.delete();
      repeat ($urandom_range(1, 24)) line_bytes.push_back(noise_byte());
      line_bytes.push_back(CH_NUL);
   endfunction

   // Sends one byte. It is entered and left on a falling edge. A new burst
   // may begin with a gap, during which tvalid is low. Once the byte is
   // accepted, its results are queued for checking.
   task automatic send_byte(input logic [7:0] ch, input logic typed = 1'b0,
                            input item_type want = '0);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 64)
                                                   : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      bytes_sent++;
      split_byte(ch);
      if (typed) begin
         awaited_runs.push_back(want);
      end else begin
         foreach (emitted[i]) awaited_runs.push_back(emitted[i]);
      end
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
      lines_sent++;
   endtask

   // ------------------------------------------------------------------
   // Receiver. It changes its stall pattern now and then: always ready,
   // random stalls, a fixed bit pattern, and a mode that is mostly stalled
   // so that the block's output queue fills and req_tready drops.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = rx_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 200);
      end
      mode_left--;
      case (stall_mode)
         RX_OPEN:    rsp_tready <= 1'b1;
         RX_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_PATTERN: rsp_tready <= stall_pattern[mode_left % 11];
         default:    rsp_tready <= (mode_left % 24) < 6;
      endcase
   end

   // Every accepted result is checked against the oldest prediction.
   always @(posedge clock) begin
      item_type got;
      item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_char     = rsp_tdata[7:0];
         got.repeat_count = rsp_tdata[23:8];
         got.arg_number   = rsp_tdata[31:24];
         got.arg_end      = rsp_tlast;
         got.line_end     = rsp_tuser[0];
         got.run_overflow = rsp_tuser[1];
         if (awaited_runs.size() == 0) begin
            $error("result item with none expected: char %02h count %0d", got.out_char,
                   got.repeat_count);
            fail_count++;
         end else begin
            want = awaited_runs.pop_front();
            results_checked++;
            if (got.out_char !== want.out_char) begin
               $error("out_char: expected %02h, got %02h", want.out_char, got.out_char);
               fail_count++;
            end
            if (got.repeat_count !== want.repeat_count) begin
               $error("repeat_count: expected %0d, got %0d", want.repeat_count,
                      got.repeat_count);
               fail_count++;
            end
            if (got.arg_end !== want.arg_end) begin
               $error("arg_end: expected %0b, got %0b", want.arg_end, got.arg_end);
               fail_count++;
            end
            if (got.line_end !== want.line_end) begin
               $error("line_end: expected %0b, got %0b", want.line_end, got.line_end);
               fail_count++;
            end
            if (got.arg_number !== want.arg_number) begin
               $error("arg_number: expected %0d, got %0d", want.arg_number, got.arg_number);
               fail_count++;
            end
            if (got.run_overflow !== want.run_overflow) begin
               $error("run_overflow: expected %0b, got %0b", want.run_overflow,
                      got.run_overflow);
               fail_count++;
            end
            if (want.run_overflow) begin
               overflow_seen++;
            end
            if (want.arg_number > top_index_seen) begin
               top_index_seen = want.arg_number;
            end
         end
      end
   end

   // The run ends here if the block stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding", cycle_count,
                  awaited_runs.size());
         $display("command_line_argument_splitter_tb: FAIL");
         $finish;
      end
   end

   initial begin
      clear_state();

      // Directed table. The first line is empty, right after reset.
      add_typed(CH_NUL, '{8'h00, 16'd0, 1'b1, 1'b1, 8'd0, 1'b0});
      // Leading blanks are skipped. In the first argument the extreme bytes
      // are literal, a quote only toggles quoting, a quoted space is kept
      // and a backslash is plain text.
      add_row(CH_SPC, 2);
      add_row(CH_TAB, 1);
      add_typed(8'h01, '{8'h01, 16'd1, 1'b0, 1'b0, 8'd0, 1'b0});
      add_typed(8'hFF, '{8'hFF, 16'd1, 1'b0, 1'b0, 8'd0, 1'b0});
      add_row(CH_QUO, 1);
      add_typed(CH_SPC, '{CH_SPC, 16'd1, 1'b0, 1'b0, 8'd0, 1'b0});
      add_row(CH_QUO, 1);
      add_typed(CH_BSL, '{CH_BSL, 16'd1, 1'b0, 1'b0, 8'd0, 1'b0});
      add_typed(CH_TAB, '{8'h00, 16'd0, 1'b1, 1'b0, 8'd0, 1'b0});
      // Second argument: an odd and an even backslash run before a quote,
      // a quote run inside quotes, a backslash run before a plain byte.
      add_row(CH_SPC, 3);
      add_row(CH_BSL, 3);
      add_row(CH_QUO, 1);
      add_row(CH_BSL, 4);
      add_row(CH_QUO, 1);
      add_row(CH_QUO, 4);
      add_row(8'h79, 1);
      add_row(CH_BSL, 2);
      add_row(8'h78, 1);
      add_row(CH_SPC, 1);
      // Line end between arguments carries the last argument's index.
      add_typed(CH_NUL, '{8'h00, 16'd0, 1'b0, 1'b1, 8'd1, 1'b0});
      // Longer backslash and quote runs, then a line end that flushes a
      // pending backslash run.
      add_row(8'h61, 1);
      add_row(CH_SPC, 1);
      add_row(CH_BSL, 9);
      add_row(CH_QUO, 1);
      add_row(CH_QUO, 1);
      add_row(CH_QUO, 10);
      add_row(8'h7A, 1);
      add_row(CH_BSL, 5);
      add_row(CH_NUL, 1);
      // Line end inside the first argument.
      add_row(8'h62, 1);
      add_row(CH_NUL, 1);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stimulus_rows[i]) begin
         repeat (stimulus_rows[i].reps) begin
            send_byte(stimulus_rows[i].ch, stimulus_rows[i].typed, stimulus_rows[i].want);
         end
      end

      // Mostly well-formed lines with random content, some loose noise, until
      // the planned number of input items has gone in.
      while (bytes_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            build_noise_line();
         end else begin
            build_line();
         end
         send_line();
      end
      req_tvalid <= 1'b0;

      while (awaited_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes, %0d random lines after the directed table; checked %0d results.",
               bytes_sent, lines_sent, results_checked);
      $display("Results with the overflow flag: %0d; highest argument index: %0d.",
               overflow_seen, top_index_seen);
      if (fail_count == 0) begin
         $display("command_line_argument_splitter_tb: PASS");
      end else begin
         $display("command_line_argument_splitter_tb: FAIL");
      end
      $finish;
   end

endmodule
